@@ sv/slist_pkg.sv @@
package slist_pkg;

	localparam int CAPACITY   = 32;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int TDATA_W    = ((DATA_WIDTH + 7) / 8) * 8;
	localparam int ACT_W      = 2;

	typedef logic signed [DATA_WIDTH-1:0] data_t;
	typedef logic [TDATA_W-1:0]           tdata_t;
	typedef logic [ACT_W-1:0]             action_t;
	typedef logic [IDX_W-1:0]             idx_t;
	typedef logic [CNT_W-1:0]             cnt_t;

	localparam action_t ACT_INSERT   = 2'd0;
	localparam action_t ACT_READ_ASC = 2'd1;
	localparam action_t ACT_READ_DSC = 2'd2;

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} state_t;

	typedef enum logic [1:0] {
		OUT_ACK,
		OUT_EMPTY,
		OUT_ENTRY
	} out_kind_t;

	// controller -> datapath
	typedef struct packed {
		logic      insert;
		logic      load;
		out_kind_t kind;
		logic      dropped;
		logic      start_read;
		logic      desc;
		logic      step;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic full;
		logic empty;
		logic at_last;
		logic out_free;
	} stat_t;

endpackage

@@ sv/slist_ctrl.sv @@
module slist_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  slist_pkg::action_t  in_action,
	output logic                in_ready,
	input  slist_pkg::stat_t    stat,
	output slist_pkg::cmd_t     cmd
);

	slist_pkg::state_t state_q, state_d;
	logic              take;

	assign in_ready = (state_q == slist_pkg::ST_IDLE) && stat.out_free;
	assign take     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= slist_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			slist_pkg::ST_IDLE: begin
				if (take && !stat.empty &&
				    (in_action == slist_pkg::ACT_READ_ASC ||
				     in_action == slist_pkg::ACT_READ_DSC)) begin
					state_d = slist_pkg::ST_READ;
				end
			end
			slist_pkg::ST_READ: begin
				if (stat.out_free && stat.at_last) begin
					state_d = slist_pkg::ST_IDLE;
				end
			end
			default: state_d = slist_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd            = '0;
		cmd.kind       = slist_pkg::OUT_ACK;
		unique case (state_q)
			slist_pkg::ST_IDLE: begin
				if (take) begin
					unique case (in_action)
						slist_pkg::ACT_INSERT: begin
							cmd.load    = 1'b1;
							cmd.kind    = slist_pkg::OUT_ACK;
							cmd.dropped = stat.full;
							cmd.insert  = !stat.full;
						end
						slist_pkg::ACT_READ_ASC, slist_pkg::ACT_READ_DSC: begin
							if (stat.empty) begin
								cmd.load = 1'b1;
								cmd.kind = slist_pkg::OUT_EMPTY;
							end else begin
								cmd.start_read = 1'b1;
								cmd.desc = (in_action == slist_pkg::ACT_READ_DSC);
							end
						end
						default: ; // unused code: request ignored
					endcase
				end
			end
			slist_pkg::ST_READ: begin
				if (stat.out_free) begin
					cmd.load = 1'b1;
					cmd.kind = slist_pkg::OUT_ENTRY;
					cmd.step = 1'b1;
				end
			end
			default: ;
		endcase
	end

endmodule

@@ sv/slist_dpath.sv @@
module slist_dpath (
	input  logic              clk,
	input  logic              arst_n,
	input  slist_pkg::data_t  value,
	input  slist_pkg::cmd_t   cmd,
	output slist_pkg::stat_t  stat,
	output logic              out_valid,
	input  logic              out_ready,
	output slist_pkg::data_t  out_item,
	output logic              out_last,
	output logic              out_dropped,
	output logic              out_empty
);

	slist_pkg::data_t cells_q [slist_pkg::CAPACITY];
	logic [slist_pkg::CAPACITY-1:0] less;
	slist_pkg::cnt_t  count_q;
	slist_pkg::idx_t  idx_q;
	logic             desc_q;
	logic             out_valid_q;
	slist_pkg::data_t item_q;
	logic             last_q, dropped_q, empty_q;
	logic             at_last;
	logic             out_free;

	// cell holds a stored value smaller than the new one: it stays put
	always_comb begin
		for (int i = 0; i < slist_pkg::CAPACITY; i++) begin
			less[i] = (slist_pkg::CNT_W'(i) < count_q) && (cells_q[i] < value);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			for (int i = 0; i < slist_pkg::CAPACITY; i++) begin
				if (!less[i]) begin
					if (i == 0) begin
						cells_q[i] <= value;
					end else if (less[i-1]) begin
						cells_q[i] <= value;
					end else begin
						cells_q[i] <= cells_q[i-1];
					end
				end
			end
		end
	end

	assign at_last = desc_q ? (idx_q == '0)
	                        : ({1'b0, idx_q} == (count_q - slist_pkg::CNT_W'(1)));
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			idx_q       <= '0;
			desc_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.insert) begin
				count_q <= count_q + slist_pkg::CNT_W'(1);
			end
			if (cmd.start_read) begin
				desc_q <= cmd.desc;
				idx_q  <= cmd.desc ? slist_pkg::IDX_W'(count_q - slist_pkg::CNT_W'(1)) : '0;
			end else if (cmd.step) begin
				idx_q <= desc_q ? idx_q - slist_pkg::IDX_W'(1) : idx_q + slist_pkg::IDX_W'(1);
			end
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dropped_q <= cmd.dropped;
			empty_q   <= (cmd.kind == slist_pkg::OUT_EMPTY);
			if (cmd.kind == slist_pkg::OUT_ENTRY) begin
				item_q <= cells_q[idx_q];
				last_q <= at_last;
			end else begin
				item_q <= '0;
				last_q <= 1'b1;
			end
		end
	end

	assign stat.full     = (count_q >= slist_pkg::CNT_W'(slist_pkg::CAPACITY));
	assign stat.empty    = (count_q == '0);
	assign stat.at_last  = at_last;
	assign stat.out_free = out_free;

	assign out_valid   = out_valid_q;
	assign out_item    = item_q;
	assign out_last    = last_q;
	assign out_dropped = dropped_q;
	assign out_empty   = empty_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= slist_pkg::CNT_W'(slist_pkg::CAPACITY))
		else $error("stored count beyond capacity");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> out_free)
		else $error("result register overwritten while pending");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.insert |=> count_q == $past(count_q) + slist_pkg::CNT_W'(1))
		else $error("insert did not grow the list by one");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> ({1'b0, idx_q} < count_q))
		else $error("readout pointer outside stored entries");

	a_insert_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.insert |-> !stat.full)
		else $error("insert into full list");

endmodule

@@ sv/sorted_list_insert_and_readout.sv @@
// Sorted list of up to 32 signed values held in a row of compare-and-shift cells. On an insert
// request every cell compares against the new value at once, the ones not smaller shift up one
// place, and one acknowledgement follows (dropped set when the list is full).
// A read request streams the stored values, ascending or descending, one per cycle while the
// master accepts them, through a single output register; an empty list answers with a single
// result flagged empty. The next request is accepted once the last result of the previous one
// has entered the output register and that register is empty or being read out; stalls on the
// master side hold the stream. Action code 3 is taken and produces no result.
module sorted_list_insert_and_readout (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  slist_pkg::tdata_t   s_tdata,  // [DATA_WIDTH-1:0] value
	input  slist_pkg::action_t  s_tuser,  // [1:0] action
	output logic                m_tvalid,
	input  logic                m_tready,
	output slist_pkg::tdata_t   m_tdata,  // [DATA_WIDTH-1:0] item
	output logic                m_tlast,
	output logic [1:0]          m_tuser   // [0] dropped, [1] empty_res
);

	slist_pkg::cmd_t  cmd;
	slist_pkg::stat_t stat;
	slist_pkg::data_t value;
	slist_pkg::data_t item;
	logic             dropped, empty_res;

	assign value = s_tdata[slist_pkg::DATA_WIDTH-1:0];

	slist_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_action (s_tuser),
		.in_ready  (s_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	slist_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.value       (value),
		.cmd         (cmd),
		.stat        (stat),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_item    (item),
		.out_last    (m_tlast),
		.out_dropped (dropped),
		.out_empty   (empty_res)
	);

	assign m_tdata = slist_pkg::tdata_t'($unsigned(item));
	assign m_tuser = {empty_res, dropped};

endmodule
